FILE: rtl/stes_pkg.sv
// ============================================================================
// stes_pkg
// shared widths, types and the reciprocal table of the evidence slicer
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package stes_pkg;

    localparam int MAX_DIMS   = 8;
    localparam int SIZE_BITS  = 8;
    localparam int INDEX_BITS = 32;
    localparam int VALUE_BITS = 64;
    localparam int CFG_BITS   = 64;
    localparam int NUM_BITS   = 4;
    localparam int MASK_BITS  = 8;
    localparam int ADDR_BITS  = 5;
    localparam int SIZE_COUNT = 1 << SIZE_BITS;
    localparam int DCNT_BITS  = $clog2(MAX_DIMS + 1);

    typedef logic [INDEX_BITS-1:0]   index_t;
    typedef logic [INDEX_BITS:0]     prod_t;
    typedef logic [2*INDEX_BITS-1:0] wide_t;
    typedef logic [SIZE_BITS-1:0]    dsize_t;
    typedef logic [VALUE_BITS-1:0]   value_t;
    typedef index_t                  recip_t;
    typedef recip_t                  recip_table_t [SIZE_COUNT];

    typedef enum logic [1:0] {
        REG_NUM_DIMS        = 2'd0,
        REG_DIM_SIZES       = 2'd1,
        REG_OBSERVED_MASK   = 2'd2,
        REG_OBSERVED_VALUES = 2'd3
    } reg_index_t;

    typedef struct packed {
        index_t idx;
        value_t value;
        index_t rem;
        index_t result;
        index_t radix;
        index_t term_radix;
        dsize_t digit;
        prod_t  product;
        logic   match;
        wide_t  mul;
    } stage_t;

    // floor(2^INDEX_BITS / s), held below 2^INDEX_BITS, by long division
    function automatic recip_table_t build_recip();
        recip_table_t        t;
        logic [INDEX_BITS:0] rem;
        logic [INDEX_BITS:0] q;
        for (int s = 0; s < SIZE_COUNT; s++) begin
            rem = '0;
            q   = '0;
            if (s != 0) begin
                for (int b = INDEX_BITS; b >= 0; b--) begin
                    rem = {rem[INDEX_BITS-1:0], (b == INDEX_BITS)};
                    if (rem >= (INDEX_BITS+1)'(s)) begin
                        rem  = rem - (INDEX_BITS+1)'(s);
                        q[b] = 1'b1;
                    end
                end
            end
            t[s] = q[INDEX_BITS] ? '1 : q[INDEX_BITS-1:0];
        end
        return t;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip();

    function automatic dsize_t field_of(input logic [CFG_BITS-1:0] word, input int d);
        dsize_t f;
        f = '0;
        if ((d + 1) * SIZE_BITS <= CFG_BITS) begin
            f = word[d*SIZE_BITS +: SIZE_BITS];
        end
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/stes_entry_if.sv
// ============================================================================
// stes_entry_if
// valid/ready channel carrying one sparse table entry
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface stes_entry_if import stes_pkg::*; ();
    logic   valid;
    logic   ready;
    index_t entry_index;
    value_t entry_value;

    modport source (output valid, output entry_index, output entry_value, input ready);
    modport sink   (input valid, input entry_index, input entry_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/stes_result_if.sv
// ============================================================================
// stes_result_if
// valid/ready channel carrying one slicer result
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface stes_result_if import stes_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   keep;
    logic   out_of_range;
    index_t new_index;
    value_t out_value;

    modport source (output valid, output keep, output out_of_range, output new_index,
                    output out_value, input ready);
    modport sink   (input valid, input keep, input out_of_range, input new_index,
                    input out_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/sparse_table_evidence_slicer_top.sv
// ============================================================================
// sparse_table_evidence_slicer_top
// splits flat indices into mixed-radix digits, checks evidence and rebuilds
// the index of the reduced table
// ============================================================================
// channel   dir  handshake      payload
// entries   in   valid/ready    entry_index, entry_value
// results   out  valid/ready    keep, out_of_range, new_index, out_value
// apb       in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// one item per cycle unless the output stalls; two stages per dimension
// (reciprocal multiply, then correction and digit check) plus a final stage
// a stall at the output freezes the whole pipeline, nothing lost or repeated
// reset clears valid bits and sets one dimension of size one; no clearing pass
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sparse_table_evidence_slicer_top import stes_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_BITS-1:0]  pwdata,
    output logic      [CFG_BITS-1:0]  prdata,
    output logic                      pready,
    stes_entry_if.sink                entries,
    stes_result_if.source             results
);

    logic [NUM_BITS-1:0]  num_dims_reg;
    logic [CFG_BITS-1:0]  dim_sizes_reg;
    logic [MASK_BITS-1:0] observed_mask_reg;
    logic [CFG_BITS-1:0]  observed_values_reg;
    recip_t               recip_reg [MAX_DIMS];

    reg_index_t           reg_sel;
    logic                 wr_en;
    logic [DCNT_BITS-1:0] used_dims;
    logic                 advance;

    stage_t a_reg [MAX_DIMS];
    stage_t a_next [MAX_DIMS];
    logic   a_valid_reg [MAX_DIMS];
    stage_t b_reg [MAX_DIMS];
    stage_t b_next [MAX_DIMS];
    logic   b_valid_reg [MAX_DIMS];

    logic   out_valid_reg;
    logic   keep_reg;
    logic   keep_next;
    logic   oor_reg;
    logic   oor_next;
    index_t new_index_reg;
    index_t new_index_next;
    value_t out_value_reg;

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[ADDR_BITS-1:3]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            REG_NUM_DIMS:        prdata = CFG_BITS'(num_dims_reg);
            REG_DIM_SIZES:       prdata = dim_sizes_reg;
            REG_OBSERVED_MASK:   prdata = CFG_BITS'(observed_mask_reg);
            REG_OBSERVED_VALUES: prdata = observed_values_reg;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg        <= NUM_BITS'(1);
            dim_sizes_reg       <= CFG_BITS'(1);
            observed_mask_reg   <= '0;
            observed_values_reg <= '0;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                recip_reg[d] <= RECIP_TABLE[field_of(CFG_BITS'(1), d)];
            end
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_NUM_DIMS:        num_dims_reg <= pwdata[NUM_BITS-1:0];
                REG_DIM_SIZES:
                begin
                    dim_sizes_reg <= pwdata;
                    for (int d = 0; d < MAX_DIMS; d++)
                    begin
                        recip_reg[d] <= RECIP_TABLE[field_of(pwdata, d)];
                    end
                end
                REG_OBSERVED_MASK:   observed_mask_reg <= pwdata[MASK_BITS-1:0];
                REG_OBSERVED_VALUES: observed_values_reg <= pwdata;
                default:             ;
            endcase
        end
    end

    // dimension count clamped to 1..MAX_DIMS
    always_comb
    begin
        if (num_dims_reg == '0)
            used_dims = DCNT_BITS'(1);
        else if (NUM_BITS'(num_dims_reg) > NUM_BITS'(MAX_DIMS))
            used_dims = DCNT_BITS'(MAX_DIMS);
        else
            used_dims = DCNT_BITS'(num_dims_reg);
    end

    assign advance       = !out_valid_reg || results.ready;
    assign entries.ready = advance;

    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_dim
        stage_t src;
        dsize_t size;
        dsize_t ev;
        logic   active;
        logic   seen;
        index_t q0;
        logic [INDEX_BITS+SIZE_BITS-1:0] qs;
        index_t r_raw;
        logic [SIZE_BITS:0] r;
        logic   fix;
        dsize_t digit;
        logic [INDEX_BITS+SIZE_BITS:0] prod_mul;

        assign size   = field_of(dim_sizes_reg, d);
        assign ev     = field_of(observed_values_reg, d);
        assign active = DCNT_BITS'(d) < used_dims;
        assign seen   = (d < MASK_BITS) ? observed_mask_reg[d % MASK_BITS] : 1'b0;

        // multiply stage: reciprocal product and the previous digit's term
        always_comb
        begin
            if (d == 0)
            begin
                src            = '0;
                src.idx        = entries.entry_index;
                src.value      = entries.entry_value;
                src.rem        = entries.entry_index;
                src.radix      = INDEX_BITS'(1);
                src.term_radix = INDEX_BITS'(1);
                src.product    = (INDEX_BITS+1)'(1);
                src.match      = 1'b1;
            end
            else
            begin
                src = b_reg[(d + MAX_DIMS - 1) % MAX_DIMS];
            end
            a_next[d]        = src;
            a_next[d].mul    = wide_t'(src.rem) * wide_t'(recip_reg[d]);
            a_next[d].result = src.result
                             + INDEX_BITS'(src.digit * src.term_radix);
            a_next[d].digit  = '0;
        end

        // correction stage: quotient, digit, evidence check
        always_comb
        begin
            q0       = a_reg[d].mul[2*INDEX_BITS-1:INDEX_BITS];
            qs       = q0 * size;
            r_raw    = a_reg[d].rem - INDEX_BITS'(qs);
            r        = r_raw[SIZE_BITS:0];
            fix      = r >= {1'b0, size};
            digit    = fix ? SIZE_BITS'(r - {1'b0, size}) : r[SIZE_BITS-1:0];
            prod_mul = a_reg[d].product * size;

            b_next[d] = a_reg[d];
            if (active)
            begin
                b_next[d].rem        = fix ? q0 + INDEX_BITS'(1) : q0;
                b_next[d].term_radix = a_reg[d].radix;
                b_next[d].digit      = seen ? '0 : digit;
                b_next[d].radix      = seen ? a_reg[d].radix
                                            : INDEX_BITS'(a_reg[d].radix * size);
                b_next[d].match      = a_reg[d].match && !(seen && digit != ev);
                b_next[d].product    = (prod_mul > (INDEX_BITS+SIZE_BITS+1)'(1) << INDEX_BITS)
                                     ? (INDEX_BITS+1)'(1) << INDEX_BITS
                                     : prod_mul[INDEX_BITS:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_valid_reg[d] <= 1'b0;
                b_valid_reg[d] <= 1'b0;
            end
            else if (advance)
            begin
                a_valid_reg[d] <= (d == 0) ? entries.valid
                                           : b_valid_reg[(d + MAX_DIMS - 1) % MAX_DIMS];
                b_valid_reg[d] <= a_valid_reg[d];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                a_reg[d] <= a_next[d];
                b_reg[d] <= b_next[d];
            end
        end
    end

    // final stage: last term and range check
    always_comb
    begin
        oor_next       = {1'b0, b_reg[MAX_DIMS-1].idx} >= b_reg[MAX_DIMS-1].product;
        keep_next      = b_reg[MAX_DIMS-1].match && !oor_next;
        new_index_next = keep_next
                       ? b_reg[MAX_DIMS-1].result
                         + INDEX_BITS'(b_reg[MAX_DIMS-1].digit * b_reg[MAX_DIMS-1].term_radix)
                       : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= b_valid_reg[MAX_DIMS-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            keep_reg      <= keep_next;
            oor_reg       <= oor_next;
            new_index_reg <= new_index_next;
            out_value_reg <= b_reg[MAX_DIMS-1].value;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.keep         = keep_reg;
    assign results.out_of_range = oor_reg;
    assign results.new_index    = new_index_reg;
    assign results.out_value    = out_value_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> !(results.keep && results.out_of_range))
        else $error("kept item flagged out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.keep) |-> (results.new_index == '0))
        else $error("dropped item has nonzero index");

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(a_valid_reg[0]) && $stable(out_valid_reg)))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/sparse_table_evidence_slicer_top_tb.sv
// ============================================================================
// sparse_table_evidence_slicer_top_tb
// streams sparse table entries through the evidence slicer under several
// table shapes and evidence settings, predicts or is given each result and compares it
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sparse_table_evidence_slicer_top_tb;
    import stes_pkg::*;

    typedef struct {
        logic   keep;
        logic   out_of_range;
        index_t new_index;
        value_t out_value;
    } slice_t;

    typedef struct {
        index_t idx;
        value_t value;
        logic   fixed;
        slice_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [CFG_BITS-1:0] pwdata;
    logic [CFG_BITS-1:0] prdata;
    logic pready;

    stes_entry_if entries ();
    stes_result_if results ();

    sparse_table_evidence_slicer_top uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .entries(entries.sink), .results(results.source)
    );

    logic [3:0] cfg_dims;
    logic [63:0] cfg_sizes;
    logic [7:0] cfg_mask;
    logic [63:0] cfg_evidence;

    slice_t pending_slices[$];
    int errors;
    int kept_count;
    int oor_count;
    int checked;
    longint cycles;
    logic stall_mode;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = 1'b1;
            #2 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic slice_t slice_entry(index_t idx, value_t value);
        slice_t s;
        int n;
        logic [63:0] product;
        logic [63:0] rem;
        logic [63:0] radix;
        logic [63:0] acc;
        logic [63:0] size;
        logic [63:0] digit;
        logic hit;
        n = (cfg_dims == 0) ? 1 : (cfg_dims > MAX_DIMS ? MAX_DIMS : int'(cfg_dims));
        product = 1;
        for (int d = 0; d < n; d++)
        begin
            product = product * cfg_sizes[d*8 +: 8];
            if (product > 64'h1_0000_0000)
                product = 64'h1_0000_0000;
        end
        s.out_value = value;
        s.keep = 1'b0;
        s.out_of_range = 1'b0;
        s.new_index = '0;
        if ({32'd0, idx} >= product)
        begin
            s.out_of_range = 1'b1;
            return s;
        end
        rem = idx;
        radix = 1;
        acc = 0;
        hit = 1'b1;
        for (int d = 0; d < n; d++)
        begin
            size = cfg_sizes[d*8 +: 8];
            digit = rem % size;
            rem = rem / size;
            if (cfg_mask[d])
            begin
                if (digit != cfg_evidence[d*8 +: 8])
                    hit = 1'b0;
            end
            else
            begin
                acc = acc + digit * radix;
                radix = radix * size;
            end
        end
        s.keep = hit;
        s.new_index = hit ? acc[31:0] : '0;
        return s;
    endfunction

    task automatic write_reg(reg_index_t r, logic [63:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(8 * int'(r));
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_NUM_DIMS: cfg_dims = v[3:0];
            REG_DIM_SIZES: cfg_sizes = v;
            REG_OBSERVED_MASK: cfg_mask = v[7:0];
            REG_OBSERVED_VALUES: cfg_evidence = v;
            default: ;
        endcase
    endtask

    task automatic set_table(logic [3:0] n, logic [63:0] sz, logic [7:0] m, logic [63:0] ev);
        write_reg(REG_NUM_DIMS, {60'd0, n});
        write_reg(REG_DIM_SIZES, sz);
        write_reg(REG_OBSERVED_MASK, {56'd0, m});
        write_reg(REG_OBSERVED_VALUES, ev);
    endtask

    task automatic drain_results();
        while (pending_slices.size() != 0)
            @(posedge clk);
        repeat (2 * MAX_DIMS + 4) @(posedge clk);
    endtask

    task automatic send_entry(index_t idx, value_t value, logic fixed, slice_t want);
        entries.valid <= 1'b1;
        entries.entry_index <= idx;
        entries.entry_value <= value;
        @(posedge clk);
        while (!entries.ready)
            @(posedge clk);
        pending_slices.push_back(fixed ? want : slice_entry(idx, value));
    endtask

    task automatic pause_entries();
        entries.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            slice_t exp_s;
            if (pending_slices.size() == 0)
            begin
                $display("%0t unexpected result keep=%b oor=%b idx=%h", $time,
                         results.keep, results.out_of_range, results.new_index);
                errors++;
            end
            else
            begin
                exp_s = pending_slices.pop_front();
                checked++;
                if (exp_s.keep) kept_count++;
                if (exp_s.out_of_range) oor_count++;
                if (results.keep !== exp_s.keep)
                begin
                    $display("%0t keep expected %b actual %b", $time,
                             exp_s.keep, results.keep);
                    errors++;
                end
                if (results.out_of_range !== exp_s.out_of_range)
                begin
                    $display("%0t out_of_range expected %b actual %b", $time,
                             exp_s.out_of_range, results.out_of_range);
                    errors++;
                end
                if (results.new_index !== exp_s.new_index)
                begin
                    $display("%0t new_index expected %h actual %h", $time,
                             exp_s.new_index, results.new_index);
                    errors++;
                end
                if (results.out_value !== exp_s.out_value)
                begin
                    $display("%0t out_value expected %h actual %h", $time,
                             exp_s.out_value, results.out_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        if (stall_mode)
            results.ready <= ($urandom_range(0, 2) != 0);
        else
            results.ready <= 1'b1;
    end

    // random shape; mostly entries in range, evidence biased to match
    task automatic random_phase(int count);
        logic [3:0] n;
        logic [63:0] sz;
        logic [63:0] ev;
        logic [7:0] m;
        logic [63:0] prod;
        index_t idx;
        int burst;
        n = 4'($urandom_range(0, 15));
        sz = {$urandom, $urandom};
        prod = 1;
        for (int d = 0; d < 8; d++)
        begin
            if ($urandom_range(0, 3) != 0)
                sz[d*8 +: 8] = 8'($urandom_range(1, 6));
            if ($urandom_range(0, 40) == 0)
                sz[d*8 +: 8] = 8'($urandom_range(0, 1) ? 0 : 255);
        end
        m = 8'($urandom);
        ev = {$urandom, $urandom};
        for (int d = 0; d < 8; d++)
        begin
            if (sz[d*8 +: 8] != 0 && $urandom_range(0, 4) != 0)
                ev[d*8 +: 8] = 8'($urandom_range(0, sz[d*8 +: 8] - 1));
            if (d < ((n == 0) ? 1 : (n > 8 ? 8 : n)))
                prod = prod * sz[d*8 +: 8];
        end
        set_table(n, sz, m, ev);
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (prod != 0 && prod < 64'h1_0000_0000 && $urandom_range(0, 9) != 0)
                idx = 32'({$urandom} % prod);
            else
                idx = $urandom;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 1)) pause_entries();
            end
            burst--;
            send_entry(idx, {$urandom, $urandom}, 1'b0, '{default: '0});
        end
        entries.valid <= 1'b0;
        drain_results();
    endtask

    row_t rows[$];

    initial
    begin
        slice_t none;
        none = '{default: '0};
        errors = 0;
        kept_count = 0;
        oor_count = 0;
        checked = 0;
        cycles = 0;
        stall_mode = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        entries.valid = 1'b0;
        entries.entry_index = '0;
        entries.entry_value = '0;
        results.ready = 1'b1;
        cfg_dims = 4'd1;
        cfg_sizes = 64'd1;
        cfg_mask = 8'd0;
        cfg_evidence = 64'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: one dimension of size one
        rows.push_back('{32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                         '{1'b1, 1'b0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF}});
        rows.push_back('{32'd1, 64'h0, 1'b1, '{1'b0, 1'b1, 32'd0, 64'h0}});
        rows.push_back('{32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA, 1'b1,
                         '{1'b0, 1'b1, 32'd0, 64'h5555_AAAA_5555_AAAA}});
        foreach (rows[i])
            send_entry(rows[i].idx, rows[i].value, rows[i].fixed, rows[i].want);
        entries.valid <= 1'b0;
        drain_results();

        // three dims 3x4x5, dim 1 observed at 2
        set_table(4'd3, 64'h05_04_03, 8'h02, 64'h00_02_00);
        for (int i = 0; i < 12; i++)
            send_entry(index_t'(i * 5 + 3), {$urandom, $urandom}, 1'b0, none);
        send_entry(32'd60, 64'h1, 1'b1, '{1'b0, 1'b1, 32'd0, 64'h1});
        entries.valid <= 1'b0;
        drain_results();

        // zero size: everything out of range; evidence not below size never matches
        set_table(4'd2, 64'h00_07, 8'h00, 64'h0);
        send_entry(32'd0, 64'h7, 1'b1, '{1'b0, 1'b1, 32'd0, 64'h7});
        entries.valid <= 1'b0;
        drain_results();
        set_table(4'd1, 64'h03, 8'h01, 64'h03);
        for (int i = 0; i < 3; i++)
            send_entry(index_t'(i), 64'h0, 1'b0, none);
        entries.valid <= 1'b0;
        drain_results();

        // huge product, dimension count above max and zero
        set_table(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_entry(32'hFFFF_FFFF, 64'h0, 1'b0, none);
        send_entry(32'h0, 64'h0, 1'b0, none);
        entries.valid <= 1'b0;
        drain_results();
        set_table(4'd0, 64'hFFFF_FFFF_FFFF_FF10, 8'hFE, 64'h0);
        send_entry(32'd15, 64'h0, 1'b0, none);
        send_entry(32'd16, 64'h0, 1'b0, none);
        entries.valid <= 1'b0;
        drain_results();

        for (int p = 0; p < 20; p++)
            random_phase(100);

        $display("checked %0d results: %0d kept, %0d out of range, 20+ table settings",
                 checked, kept_count, oor_count);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire
